// ===== src/b256pad_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b256pad_pkg
// Types and constants shared by the BLAKE-256 message padder modules.
// ----------------------------------------------------------------------------
package b256pad_pkg;

  localparam logic CMD_NIBBLE = 1'b0;
  localparam logic CMD_END    = 1'b1;

  // nibble position inside a 512-bit block
  localparam logic [6:0] POS_PAD_LAST  = 7'd111;
  localparam logic [6:0] POS_LEN_START = 7'd112;

  localparam logic [3:0] NIB_PAD_FIRST = 4'h8;
  localparam logic [3:0] NIB_PAD_LAST  = 4'h1;
  localparam logic [3:0] NIB_PAD_ONLY  = 4'h9;
  localparam logic [3:0] NIB_ZERO      = 4'h0;

  localparam logic [3:0] LEN_NIB_LAST  = 4'd15;
  localparam logic [3:0] WORD_LAST     = 4'd15;
  localparam logic [2:0] NIB_IN_WORD_LAST = 3'd7;

  typedef struct packed {
    logic       cmd;
    logic [3:0] nibble;
  } in_t;

  typedef struct packed {
    logic [31:0] word;
    logic        block_end;
    logic        message_end;
    logic        extra_block;
  } out_t;

  typedef enum logic [1:0] {
    ST_DATA,
    ST_PAD,
    ST_LEN
  } state_t;

  typedef struct packed {
    logic       push;
    logic [3:0] nib;
    logic       add_len;
    logic       shift_len;
    logic       final_word;
    logic       latch_extra;
  } dp_cmd_t;

  typedef struct packed {
    logic [6:0] pos;
    logic [3:0] len_nib;
    logic       can_load;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== src/b256pad_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b256pad_dp
// Datapath: nibble packer, bit length counter and output register.
// ----------------------------------------------------------------------------
module b256pad_dp (
  input  wire                        clk,
  input  wire                        rst,
  input  wire b256pad_pkg::dp_cmd_t  cmd,
  output b256pad_pkg::dp_stat_t      stat,
  output logic                       out_valid,
  input  wire                        out_ready,
  output b256pad_pkg::out_t          out_data
);
  import b256pad_pkg::*;

  logic [63:0] bit_length;
  logic [31:0] partial_word;
  logic [2:0]  nib_cnt;
  logic [3:0]  wib;
  logic        extra_flag;
  logic [31:0] word_next;
  logic        can_load;

  assign word_next = {partial_word[27:0], cmd.nib};
  assign can_load  = !out_valid || out_ready;

  always_comb begin
    stat.pos      = {wib, nib_cnt};
    stat.len_nib  = bit_length[63:60];
    stat.can_load = can_load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_length <= '0;
      nib_cnt    <= '0;
      wib        <= '0;
      extra_flag <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.latch_extra)
        extra_flag <= ({wib, nib_cnt} == 7'd0) || ({wib, nib_cnt} >= POS_LEN_START);
      if (cmd.add_len) bit_length <= bit_length + 64'd4;
      if (cmd.shift_len) bit_length <= {bit_length[59:0], 4'h0};
      if (cmd.push) begin
        partial_word <= word_next;
        if (nib_cnt == NIB_IN_WORD_LAST) begin
          nib_cnt              <= '0;
          wib                  <= wib + 4'd1;
          out_valid            <= 1'b1;
          out_data.word        <= word_next;
          out_data.block_end   <= (wib == WORD_LAST);
          out_data.message_end <= cmd.final_word;
          out_data.extra_block <= cmd.final_word & extra_flag;
        end else begin
          nib_cnt <= nib_cnt + 3'd1;
        end
      end
    end
  end

  a_extra_on_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.extra_block |-> out_data.message_end)
    else $error("extra_block without message_end");

  a_end_on_block: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.message_end |-> out_data.block_end)
    else $error("message end not on block boundary");

  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    cmd.push && cmd.final_word |=> bit_length == 64'd0 && nib_cnt == 3'd0 && wib == 4'd0)
    else $error("state not cleared after message end");

endmodule
`default_nettype wire

// ===== src/b256pad_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// b256pad_ctrl
// Controller: takes input beats and sequences padding and length nibbles.
// ----------------------------------------------------------------------------
module b256pad_ctrl (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire b256pad_pkg::in_t       in_data,
  input  wire b256pad_pkg::dp_stat_t  stat,
  output b256pad_pkg::dp_cmd_t        cmd
);
  import b256pad_pkg::*;

  state_t     state, state_next;
  logic       first_pad, first_pad_next;
  logic [3:0] len_idx, len_idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_DATA;
      first_pad <= 1'b0;
      len_idx   <= '0;
    end else begin
      state     <= state_next;
      first_pad <= first_pad_next;
      len_idx   <= len_idx_next;
    end
  end

  always_comb begin
    state_next     = state;
    first_pad_next = first_pad;
    len_idx_next   = len_idx;
    in_ready       = 1'b0;
    cmd            = '0;
    case (state)
      ST_DATA: begin
        in_ready = stat.can_load;
        if (in_valid && stat.can_load) begin
          if (in_data.cmd == CMD_NIBBLE) begin
            cmd.push    = 1'b1;
            cmd.nib     = in_data.nibble;
            cmd.add_len = 1'b1;
          end else begin
            cmd.latch_extra = 1'b1;
            first_pad_next  = 1'b1;
            state_next      = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (stat.can_load) begin
          cmd.push       = 1'b1;
          first_pad_next = 1'b0;
          if (stat.pos == POS_PAD_LAST)
            cmd.nib = first_pad ? NIB_PAD_ONLY : NIB_PAD_LAST;
          else
            cmd.nib = first_pad ? NIB_PAD_FIRST : NIB_ZERO;
          if (stat.pos == POS_PAD_LAST) begin
            len_idx_next = '0;
            state_next   = ST_LEN;
          end
        end
      end
      ST_LEN: begin
        if (stat.can_load) begin
          cmd.push      = 1'b1;
          cmd.nib       = stat.len_nib;
          cmd.shift_len = 1'b1;
          len_idx_next  = len_idx + 4'd1;
          if (len_idx == LEN_NIB_LAST) begin
            cmd.final_word = 1'b1;
            state_next     = ST_DATA;
          end
        end
      end
      default: begin
        state_next = ST_DATA;
      end
    endcase
  end

  a_len_aligned: assert property (@(posedge clk) disable iff (rst)
    state == ST_LEN |-> stat.pos == {3'b111, len_idx})
    else $error("length field not aligned to block tail");

  a_pad_no_input: assert property (@(posedge clk) disable iff (rst)
    state != ST_DATA |-> !in_ready)
    else $error("input taken during padding");

endmodule
`default_nettype wire

// ===== src/blake256_message_padder_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// blake256_message_padder_top
// BLAKE-256 message padder: nibbles in, padded 32-bit words out.
// ----------------------------------------------------------------------------
// Input beats carry cmd and nibble. A data nibble (cmd 0) is packed, first
// nibble most significant, into 32-bit words; data beats are taken one per
// cycle, and the beat that completes a word shows it on the output in the
// next cycle. An end beat (cmd 1) starts padding: the 1-zeros-1 pattern
// and the 64-bit bit length are shifted in one nibble per cycle by the
// padding sequencer, so after an end beat the input stays closed until the
// last length nibble is in, and 3 to 18 words come out; the last word has
// message_end set, and extra_block tells whether a whole block was added.
// A beat enters only while the output register is empty or its word is
// taken in that cycle; when the receiver stalls with a word held, input and
// padding wait with it.
// Reset clears the length, word position and output valid; the block is
// ready as soon as reset drops. After the final word the length and word
// position are back at reset, so the next nibble begins a new message.
// ----------------------------------------------------------------------------
module blake256_message_padder_top (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire b256pad_pkg::in_t   in_data,
  output logic                    out_valid,
  input  wire                     out_ready,
  output b256pad_pkg::out_t       out_data
);
  import b256pad_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  b256pad_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .stat     (stat),
    .cmd      (cmd)
  );

  b256pad_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
